FILE: rtl/lsem_pkg.sv
package lsem_pkg;

    localparam int LEVEL_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int ERR_W      = 10;
    localparam int CONF_W     = 8;
    localparam int ZONE_W     = 3;
    localparam int SPAN_W     = 8;
    localparam int QUO_W      = 8;
    localparam int DIVIDEND_W = SPAN_W + LEVEL_W;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTERED_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD_LEVEL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LEVEL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BARELY_LEVEL    = 3'd4;

    localparam logic [LEVEL_W-1:0] RST_BLACK_THRESHOLD = 12'd400;
    localparam logic [LEVEL_W-1:0] RST_CENTERED_LEVEL  = 12'd2000;
    localparam logic [LEVEL_W-1:0] RST_GOOD_LEVEL      = 12'd1650;
    localparam logic [LEVEL_W-1:0] RST_EDGE_LEVEL      = 12'd1200;
    localparam logic [LEVEL_W-1:0] RST_BARELY_LEVEL    = 12'd800;

    // Request codes.
    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // Low-pass filter: new = old + 38 * (in - old) / 256, i.e. alpha 38/256.
    localparam logic [5:0] ALPHA_GAIN  = 6'd38;
    localparam int         ALPHA_SHIFT = 8;

    // Zone codes.
    localparam logic [ZONE_W-1:0] ZONE_LOST    = 3'd0;
    localparam logic [ZONE_W-1:0] ZONE_CENTRED = 3'd1;
    localparam logic [ZONE_W-1:0] ZONE_GOOD    = 3'd2;
    localparam logic [ZONE_W-1:0] ZONE_EDGE    = 3'd3;
    localparam logic [ZONE_W-1:0] ZONE_BARELY  = 3'd4;
    localparam logic [ZONE_W-1:0] ZONE_FRINGE  = 3'd5;

    // Error bases and spans, and confidences, all in units of 1/256.
    localparam logic [ERR_W-1:0]  LOST_ERROR    = 10'd768;
    localparam logic [ERR_W-1:0]  BASE_GOOD     = 10'd0;
    localparam logic [ERR_W-1:0]  BASE_EDGE     = 10'd128;
    localparam logic [ERR_W-1:0]  BASE_BARELY   = 10'd333;
    localparam logic [ERR_W-1:0]  BASE_FRINGE   = 10'd563;
    localparam logic [SPAN_W-1:0] SPAN_GOOD     = 8'd128;
    localparam logic [SPAN_W-1:0] SPAN_EDGE     = 8'd205;
    localparam logic [SPAN_W-1:0] SPAN_BARELY   = 8'd230;
    localparam logic [SPAN_W-1:0] SPAN_FRINGE   = 8'd205;
    localparam logic [CONF_W-1:0] CONF_LOST     = 8'd0;
    localparam logic [CONF_W-1:0] CONF_CENTRED  = 8'd128;
    localparam logic [CONF_W-1:0] CONF_GOOD     = 8'd243;
    localparam logic [CONF_W-1:0] CONF_EDGE     = 8'd205;
    localparam logic [CONF_W-1:0] CONF_BARELY   = 8'd154;
    localparam logic [CONF_W-1:0] CONF_FRINGE   = 8'd102;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT,
        ST_ZONE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/lsem_req_if.sv
interface lsem_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [lsem_pkg::LEVEL_W-1:0] sample;

    modport source (output valid, output req_type, output sample, input ready);
    modport sink   (input valid, input req_type, input sample, output ready);
endinterface

FILE: rtl/lsem_res_if.sv
interface lsem_res_if;
    logic                         valid;
    logic                         ready;
    logic [lsem_pkg::LEVEL_W-1:0] filtered_level;
    logic                         line_seen;
    logic [lsem_pkg::ERR_W-1:0]   steer_error;
    logic [lsem_pkg::CONF_W-1:0]  confidence;
    logic [lsem_pkg::ZONE_W-1:0]  zone;

    modport source (output valid, output filtered_level, output line_seen,
                    output steer_error, output confidence, output zone, input ready);
    modport sink   (input valid, input filtered_level, input line_seen,
                    input steer_error, input confidence, input zone, output ready);
endinterface

FILE: rtl/lsem_div.sv
module lsem_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [lsem_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [lsem_pkg::LEVEL_W-1:0]    divisor,
    output logic [lsem_pkg::QUO_W-1:0]      quotient,
    output logic                            done
);
    import lsem_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic [DIVIDEND_W-1:0] rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] dsr_reg, dsr_next;
    logic [QUO_W-1:0]      quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    // Restoring division, one quotient bit a cycle. The caller guarantees
    // that the quotient fits in QUO_W bits, so the divisor starts shifted
    // up by QUO_W-1 places.
    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            dsr_next  = DIVIDEND_W'(divisor) << (QUO_W - 1);
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsr_reg)
            begin
                rem_next = rem_reg - dsr_reg;
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            dsr_next = dsr_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

FILE: rtl/line_sensor_error_mapper.sv
// A sample beat passes the filter, zone and multiply states and, when its ratio goes
// through the serial divider, the divide state; every other sample beat (lost, centred,
// clamped ratio or empty zone) skips the divider. A restart beat gives no result.
// The next beat is accepted once the result sits in the output register, which takes it
// only when no untaken result is held there; the serial divider makes the longer path.
// Reset (asynchronous, active low) unseeds the filter, clears it and loads the default levels.
module line_sensor_error_mapper #(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    lsem_req_if.sink                       req,
    lsem_res_if.source                     res,
    input  logic                           cfg_we,
    input  logic [lsem_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lsem_pkg::LEVEL_W-1:0]   cfg_wdata
);
    import lsem_pkg::*;

    localparam int FW = SAMPLE_BITS + FRAC_BITS;
    localparam int LW = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

    state_t state_reg, state_next;

    logic [LEVEL_W-1:0] thr_reg, cen_reg, good_reg, edge_reg, bar_reg;

    logic [SAMPLE_BITS-1:0] smp_in;
    logic [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic [FW-1:0]          fv_reg, fv_next;
    logic                   seeded_reg, seeded_next;

    logic                   seen_reg, seen_next;
    logic [ZONE_W-1:0]      zone_reg, zone_next;
    logic [ERR_W-1:0]       base_reg, base_next;
    logic [SPAN_W-1:0]      span_reg, span_next;
    logic [CONF_W-1:0]      conf_reg, conf_next;
    logic signed [LEVEL_W:0] num_reg, num_next;
    logic signed [LEVEL_W:0] den_reg, den_next;
    logic                   direct_reg, direct_next;
    logic [ERR_W-1:0]       err_reg, err_next;

    logic                   ov_reg, ov_next;
    logic [LEVEL_W-1:0]     o_lvl_reg, o_lvl_next;
    logic                   o_seen_reg, o_seen_next;
    logic [ERR_W-1:0]       o_err_reg, o_err_next;
    logic [CONF_W-1:0]      o_conf_reg, o_conf_next;
    logic [ZONE_W-1:0]      o_zone_reg, o_zone_next;

    logic [FW-1:0]          x_val;
    logic signed [FW:0]     diff;
    logic signed [FW+7:0]   step_prod;
    logic signed [FW+7:0]   step_shr;
    logic signed [FW+7:0]   filt_sum;
    logic [LW-1:0]          lvl_w;
    logic [LEVEL_W-1:0]     lvl12;
    logic [LEVEL_W-1:0]     upper;
    logic [LEVEL_W-1:0]     lower;

    logic                   div_start;
    logic [DIVIDEND_W-1:0]  div_dividend;
    logic [QUO_W-1:0]       div_quo;
    logic                   div_done;

    generate
        if (SAMPLE_BITS <= LEVEL_W)
        begin : g_smp_narrow
            assign smp_in = req.sample[SAMPLE_BITS-1:0];
        end
        else
        begin : g_smp_wide
            assign smp_in = {{(SAMPLE_BITS - LEVEL_W){1'b0}}, req.sample};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= RST_BLACK_THRESHOLD;
            cen_reg  <= RST_CENTERED_LEVEL;
            good_reg <= RST_GOOD_LEVEL;
            edge_reg <= RST_EDGE_LEVEL;
            bar_reg  <= RST_BARELY_LEVEL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BLACK_THRESHOLD: thr_reg  <= cfg_wdata;
                CFG_CENTERED_LEVEL:  cen_reg  <= cfg_wdata;
                CFG_GOOD_LEVEL:      good_reg <= cfg_wdata;
                CFG_EDGE_LEVEL:      edge_reg <= cfg_wdata;
                CFG_BARELY_LEVEL:    bar_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Filter update written as old + 38 * (in - old) >>> 8, which floors exactly
    // as (218 * old + 38 * in) >> 8 does.
    assign x_val     = {smp_reg, {FRAC_BITS{1'b0}}};
    assign diff      = $signed({1'b0, x_val}) - $signed({1'b0, fv_reg});
    assign step_prod = diff * $signed({1'b0, ALPHA_GAIN});
    assign step_shr  = step_prod >>> ALPHA_SHIFT;
    assign filt_sum  = $signed({8'b0, fv_reg}) + step_shr;

    assign lvl_w = LW'(fv_reg[FW-1:FRAC_BITS]);
    assign lvl12 = lvl_w[LEVEL_W-1:0];

    assign div_dividend = DIVIDEND_W'(span_reg) * DIVIDEND_W'(num_reg[LEVEL_W-1:0]);

    always_comb
    begin
        state_next  = state_reg;
        smp_next    = smp_reg;
        fv_next     = fv_reg;
        seeded_next = seeded_reg;
        seen_next   = seen_reg;
        zone_next   = zone_reg;
        base_next   = base_reg;
        span_next   = span_reg;
        conf_next   = conf_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        direct_next = direct_reg;
        err_next    = err_reg;
        ov_next     = ov_reg;
        o_lvl_next  = o_lvl_reg;
        o_seen_next = o_seen_reg;
        o_err_next  = o_err_reg;
        o_conf_next = o_conf_reg;
        o_zone_next = o_zone_reg;
        div_start   = 1'b0;
        upper       = cen_reg;
        lower       = good_reg;

        if (ov_reg && res.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.req_type == REQ_RESTART)
                    begin
                        seeded_next = 1'b0;
                    end
                    else
                    begin
                        smp_next   = smp_in;
                        state_next = ST_FILT;
                    end
                end
            end

            ST_FILT:
            begin
                fv_next     = seeded_reg ? filt_sum[FW-1:0] : x_val;
                seeded_next = 1'b1;
                state_next  = ST_ZONE;
            end

            ST_ZONE:
            begin
                direct_next = 1'b0;
                seen_next   = (lvl_w >= LW'(thr_reg));
                if (lvl_w < LW'(thr_reg))
                begin
                    zone_next   = ZONE_LOST;
                    base_next   = LOST_ERROR;
                    span_next   = '0;
                    conf_next   = CONF_LOST;
                    direct_next = 1'b1;
                end
                else if (lvl_w >= LW'(cen_reg))
                begin
                    zone_next   = ZONE_CENTRED;
                    base_next   = '0;
                    span_next   = '0;
                    conf_next   = CONF_CENTRED;
                    direct_next = 1'b1;
                end
                else if (lvl_w >= LW'(good_reg))
                begin
                    zone_next = ZONE_GOOD;
                    base_next = BASE_GOOD;
                    span_next = SPAN_GOOD;
                    conf_next = CONF_GOOD;
                    upper     = cen_reg;
                    lower     = good_reg;
                end
                else if (lvl_w >= LW'(edge_reg))
                begin
                    zone_next = ZONE_EDGE;
                    base_next = BASE_EDGE;
                    span_next = SPAN_EDGE;
                    conf_next = CONF_EDGE;
                    upper     = good_reg;
                    lower     = edge_reg;
                end
                else if (lvl_w >= LW'(bar_reg))
                begin
                    zone_next = ZONE_BARELY;
                    base_next = BASE_BARELY;
                    span_next = SPAN_BARELY;
                    conf_next = CONF_BARELY;
                    upper     = edge_reg;
                    lower     = bar_reg;
                end
                else
                begin
                    zone_next = ZONE_FRINGE;
                    base_next = BASE_FRINGE;
                    span_next = SPAN_FRINGE;
                    conf_next = CONF_FRINGE;
                    upper     = bar_reg;
                    lower     = thr_reg;
                end
                // The level is below the upper bound in every sloped zone, so
                // its low twelve bits are the whole level there.
                num_next   = $signed({1'b0, upper}) - $signed({1'b0, lvl12});
                den_next   = $signed({1'b0, upper}) - $signed({1'b0, lower});
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                if (direct_reg || den_reg[LEVEL_W] || (den_reg == '0)
                    || num_reg[LEVEL_W] || (num_reg == '0))
                begin
                    err_next   = base_reg;
                    state_next = ST_DONE;
                end
                else if (num_reg >= den_reg)
                begin
                    err_next   = base_reg + ERR_W'(span_reg);
                    state_next = ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    err_next   = base_reg + ERR_W'(div_quo);
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!ov_reg || res.ready)
                begin
                    ov_next     = 1'b1;
                    o_lvl_next  = lvl12;
                    o_seen_next = seen_reg;
                    o_err_next  = err_reg;
                    o_conf_next = conf_reg;
                    o_zone_next = zone_reg;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fv_reg     <= '0;
            seeded_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fv_reg     <= fv_next;
            seeded_reg <= seeded_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg    <= smp_next;
        seen_reg   <= seen_next;
        zone_reg   <= zone_next;
        base_reg   <= base_next;
        span_reg   <= span_next;
        conf_reg   <= conf_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        direct_reg <= direct_next;
        err_reg    <= err_next;
        o_lvl_reg  <= o_lvl_next;
        o_seen_reg <= o_seen_next;
        o_err_reg  <= o_err_next;
        o_conf_reg <= o_conf_next;
        o_zone_reg <= o_zone_next;
    end

    lsem_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (den_reg[LEVEL_W-1:0]),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign req.ready          = (state_reg == ST_IDLE);
    assign res.valid          = ov_reg;
    assign res.filtered_level = o_lvl_reg;
    assign res.line_seen      = o_seen_reg;
    assign res.steer_error    = o_err_reg;
    assign res.confidence     = o_conf_reg;
    assign res.zone           = o_zone_reg;

endmodule

FILE: tb/tb_line_sensor_error_mapper.sv
`timescale 1ns / 1ps

module tb_line_sensor_error_mapper;
    import lsem_pkg::*;

    localparam int FILT_KEEP    = 218;
    localparam int FILT_TAKE    = 38;
    localparam int FILT_FRAC    = 8;
    localparam int MAX_LEVEL    = (1 << LEVEL_W) - 1;
    localparam int PHASE_ITEMS  = 240;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int FIRST_SPARE_IDX = CFG_BARELY_LEVEL + 1;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               seen;
        logic [ERR_W-1:0]   err;
        logic [CONF_W-1:0]  conf;
        logic [ZONE_W-1:0]  zone;
    } steer_result_t;

    class steer_error_board;
        logic [LEVEL_W-1:0] black_thr;
        logic [LEVEL_W-1:0] centred_lvl;
        logic [LEVEL_W-1:0] good_lvl;
        logic [LEVEL_W-1:0] edge_lvl;
        logic [LEVEL_W-1:0] barely_lvl;
        logic [LEVEL_W+FILT_FRAC-1:0] filt_acc;
        bit            seeded;
        steer_result_t expected_q[$];
        int            fail_count;
        int            checked;
        int            samples;
        int            restarts;
        int            zone_hits[ZONE_FRINGE+1];

        function new();
            black_thr   = RST_BLACK_THRESHOLD;
            centred_lvl = RST_CENTERED_LEVEL;
            good_lvl    = RST_GOOD_LEVEL;
            edge_lvl    = RST_EDGE_LEVEL;
            barely_lvl  = RST_BARELY_LEVEL;
            filt_acc    = '0;
            seeded      = 1'b0;
            fail_count  = 0;
            checked     = 0;
            samples     = 0;
            restarts    = 0;
            foreach (zone_hits[i])
                zone_hits[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
            case (idx)
                CFG_BLACK_THRESHOLD: black_thr   = val;
                CFG_CENTERED_LEVEL:  centred_lvl = val;
                CFG_GOOD_LEVEL:      good_lvl    = val;
                CFG_EDGE_LEVEL:      edge_lvl    = val;
                CFG_BARELY_LEVEL:    barely_lvl  = val;
                default: ;
            endcase
        endfunction

        // Linear interpolation across one zone, with the ratio held to the range 0 to 1.
        function logic [ERR_W-1:0] slope(int base, int span, int upper, int lower, int lvl);
            int num;
            int den;
            num = upper - lvl;
            den = upper - lower;
            if (den <= 0 || num <= 0)
                return ERR_W'(base);
            if (num >= den)
                return ERR_W'(base + span);
            return ERR_W'(base + (span * num) / den);
        endfunction

        function void note_request(logic rt, logic [LEVEL_W-1:0] smp);
            steer_result_t r;
            int acc;
            int lvl;
            if (rt == REQ_RESTART)
            begin
                seeded = 1'b0;
                restarts++;
                return;
            end
            samples++;
            if (seeded)
            begin
                acc = (FILT_KEEP * int'(filt_acc) + FILT_TAKE * (int'(smp) << FILT_FRAC)) / 256;
                filt_acc = acc[LEVEL_W+FILT_FRAC-1:0];
            end
            else
            begin
                filt_acc = {smp, {FILT_FRAC{1'b0}}};
                seeded = 1'b1;
            end
            lvl = int'(filt_acc[LEVEL_W+FILT_FRAC-1:FILT_FRAC]);

            r.level = filt_acc[LEVEL_W+FILT_FRAC-1:FILT_FRAC];
            r.seen  = (lvl >= int'(black_thr));
            if (!r.seen)
            begin
                r.err  = 10'd768;
                r.conf = 8'd0;
                r.zone = ZONE_LOST;
            end
            else if (lvl >= int'(centred_lvl))
            begin
                r.err  = 10'd0;
                r.conf = 8'd128;
                r.zone = ZONE_CENTRED;
            end
            else if (lvl >= int'(good_lvl))
            begin
                r.err  = slope(0, 128, int'(centred_lvl), int'(good_lvl), lvl);
                r.conf = 8'd243;
                r.zone = ZONE_GOOD;
            end
            else if (lvl >= int'(edge_lvl))
            begin
                r.err  = slope(128, 205, int'(good_lvl), int'(edge_lvl), lvl);
                r.conf = 8'd205;
                r.zone = ZONE_EDGE;
            end
            else if (lvl >= int'(barely_lvl))
            begin
                r.err  = slope(333, 230, int'(edge_lvl), int'(barely_lvl), lvl);
                r.conf = 8'd154;
                r.zone = ZONE_BARELY;
            end
            else
            begin
                r.err  = slope(563, 205, int'(barely_lvl), int'(black_thr), lvl);
                r.conf = 8'd102;
                r.zone = ZONE_FRINGE;
            end
            zone_hits[r.zone]++;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            fail_count++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task cmp_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0d, expected %0d", checked, name, got, want));
        endtask

        task check_result(logic [LEVEL_W-1:0] level, logic seen, logic [ERR_W-1:0] err,
                          logic [CONF_W-1:0] conf, logic [ZONE_W-1:0] zn);
            steer_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result beat with nothing expected: level %0d zone %0d",
                                 level, zn));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            cmp_field("filtered_level", 16'(level), 16'(want.level));
            cmp_field("line_seen", 16'(seen), 16'(want.seen));
            cmp_field("steer_error", 16'(err), 16'(want.err));
            cmp_field("confidence", 16'(conf), 16'(want.conf));
            cmp_field("zone", 16'(zn), 16'(want.zone));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEVEL_W-1:0]   cfg_wdata;

    lsem_req_if req_ch();
    lsem_res_if res_ch();

    steer_error_board board;
    int gap_pct;
    bit hold_wanted;
    int level_settings;

    line_sensor_error_mapper uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still outstanding", board.expected_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_wanted)
            begin
                hold_wanted = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                res_ch.ready <= rst_n && ($urandom_range(0, 99) >= gap_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && req_ch.valid && req_ch.ready)
            board.note_request(req_ch.req_type, req_ch.sample);

    always @(posedge clk)
        if (rst_n && res_ch.valid && res_ch.ready)
            board.check_result(res_ch.filtered_level, res_ch.line_seen, res_ch.steer_error,
                               res_ch.confidence, res_ch.zone);

    task automatic send_beat(input logic rt, input logic [LEVEL_W-1:0] smp);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.sample   <= smp;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // The first edge lets the input monitor log the final beat before the queue is read.
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        board.set_reg(idx, val);
    endtask

    task automatic set_levels(input logic [LEVEL_W-1:0] blk, input logic [LEVEL_W-1:0] ctr,
                              input logic [LEVEL_W-1:0] gd, input logic [LEVEL_W-1:0] edg,
                              input logic [LEVEL_W-1:0] brl);
        write_cfg(CFG_BLACK_THRESHOLD, blk);
        write_cfg(CFG_CENTERED_LEVEL, ctr);
        write_cfg(CFG_GOOD_LEVEL, gd);
        write_cfg(CFG_EDGE_LEVEL, edg);
        write_cfg(CFG_BARELY_LEVEL, brl);
        // A write to an index past the last register must leave every level alone.
        write_cfg(CFG_IDX_W'($urandom_range(FIRST_SPARE_IDX, (1 << CFG_IDX_W) - 1)),
                  LEVEL_W'($urandom));
        cfg_we <= 1'b0;
        level_settings++;
    endtask

    task automatic random_ordered_levels(input int lo, input int hi);
        int lv[$];
        repeat (5) lv.push_back(int'($urandom_range(lo, hi)));
        lv.rsort();
        set_levels(LEVEL_W'(lv[4]), LEVEL_W'(lv[0]), LEVEL_W'(lv[1]), LEVEL_W'(lv[2]),
                   LEVEL_W'(lv[3]));
    endtask

    function automatic int pick_target();
        case ($urandom_range(0, 5))
            0: return int'(board.black_thr) + int'($urandom_range(0, 40)) - 20;
            1: return int'(board.centred_lvl) + int'($urandom_range(0, 40)) - 20;
            2: return int'(board.good_lvl) + int'($urandom_range(0, 40)) - 20;
            3: return int'(board.edge_lvl) + int'($urandom_range(0, 40)) - 20;
            4: return int'(board.barely_lvl) + int'($urandom_range(0, 40)) - 20;
            default: return int'($urandom_range(0, MAX_LEVEL));
        endcase
    endfunction

    // Mostly runs of samples hovering round a level, so that the slow filter settles
    // into each zone; the rest is unrelated noise with the odd restart.
    task automatic random_traffic(input int n_items);
        int sent;
        int target;
        int spread;
        int smp;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                if ($urandom_range(0, 99) < 40)
                begin
                    send_beat(REQ_RESTART, LEVEL_W'($urandom));
                    sent++;
                end
                target = pick_target();
                spread = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 400))
                                                     : int'($urandom_range(0, 30));
                repeat ($urandom_range(3, 40))
                begin
                    smp = target + int'($urandom_range(0, 2 * spread)) - spread;
                    if (smp < 0)
                        smp = 0;
                    if (smp > MAX_LEVEL)
                        smp = MAX_LEVEL;
                    send_beat(REQ_SAMPLE, LEVEL_W'(smp));
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                begin
                    send_beat(($urandom_range(0, 9) == 0) ? REQ_RESTART : REQ_SAMPLE,
                              LEVEL_W'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        logic [LEVEL_W-1:0] bound_samples[$];
        int lo;

        board = new();
        rst_n = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_SAMPLE;
        req_ch.sample   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_BLACK_THRESHOLD;
        cfg_wdata = '0;
        gap_pct = 30;
        hold_wanted = 1'b0;
        level_settings = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset levels: seeding after reset, full scale,
        // decay from full scale, each zone boundary seeded exactly, double restart.
        send_beat(REQ_SAMPLE, '0);
        send_beat(REQ_RESTART, LEVEL_W'($urandom));
        send_beat(REQ_SAMPLE, LEVEL_W'(MAX_LEVEL));
        send_beat(REQ_SAMPLE, '0);
        bound_samples = '{RST_CENTERED_LEVEL, LEVEL_W'(RST_CENTERED_LEVEL - 1),
                          RST_GOOD_LEVEL, LEVEL_W'(RST_GOOD_LEVEL - 1),
                          RST_EDGE_LEVEL, LEVEL_W'(RST_EDGE_LEVEL - 1),
                          RST_BARELY_LEVEL, LEVEL_W'(RST_BARELY_LEVEL - 1),
                          RST_BLACK_THRESHOLD, LEVEL_W'(RST_BLACK_THRESHOLD - 1)};
        foreach (bound_samples[i])
        begin
            send_beat(REQ_RESTART, LEVEL_W'($urandom));
            send_beat(REQ_SAMPLE, bound_samples[i]);
        end
        send_beat(REQ_RESTART, '0);
        send_beat(REQ_RESTART, LEVEL_W'(MAX_LEVEL));
        send_beat(REQ_SAMPLE, LEVEL_W'(MAX_LEVEL));
        settle();

        set_levels('0, '0, '0, '0, '0);
        random_traffic(PHASE_ITEMS);
        settle();

        set_levels(LEVEL_W'(MAX_LEVEL), LEVEL_W'(MAX_LEVEL), LEVEL_W'(MAX_LEVEL),
                   LEVEL_W'(MAX_LEVEL), LEVEL_W'(MAX_LEVEL));
        random_traffic(PHASE_ITEMS);
        settle();

        random_ordered_levels(0, MAX_LEVEL);
        gap_pct = 0;
        random_traffic(PHASE_ITEMS);
        settle();
        gap_pct = 30;

        // Unordered levels; the result side also stalls long enough for the input to back up.
        set_levels(LEVEL_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom),
                   LEVEL_W'($urandom), LEVEL_W'($urandom));
        hold_wanted = 1'b1;
        random_traffic(PHASE_ITEMS);
        settle();

        lo = int'($urandom_range(400, 3900));
        random_ordered_levels(lo, lo + 120);
        random_traffic(PHASE_ITEMS);
        settle();

        set_levels(12'd3500, 12'd300, 12'd900, 12'd1800, 12'd2600);
        random_traffic(PHASE_ITEMS);
        settle();

        random_ordered_levels(0, MAX_LEVEL);
        random_traffic(PHASE_ITEMS);
        settle();

        set_levels(RST_BLACK_THRESHOLD, RST_CENTERED_LEVEL, RST_GOOD_LEVEL,
                   RST_EDGE_LEVEL, RST_BARELY_LEVEL);
        random_traffic(PHASE_ITEMS);
        settle();

        $display("Sent %0d samples and %0d restarts over %0d level settings; %0d results checked.",
                 board.samples, board.restarts, level_settings, board.checked);
        $display("Zones seen: lost %0d, centred %0d, good %0d, edge %0d, barely %0d, fringe %0d.",
                 board.zone_hits[ZONE_LOST], board.zone_hits[ZONE_CENTRED],
                 board.zone_hits[ZONE_GOOD], board.zone_hits[ZONE_EDGE],
                 board.zone_hits[ZONE_BARELY], board.zone_hits[ZONE_FRINGE]);
        if (board.fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lsem_pkg.sv
rtl/lsem_req_if.sv
rtl/lsem_res_if.sv
rtl/lsem_div.sv
rtl/line_sensor_error_mapper.sv
tb/tb_line_sensor_error_mapper.sv
